>>> rtl/core/dsrd_pkg.sv
// ----------------------------------------------------------------------------
// dsrd_pkg
// Shared widths, register indexes and types of the depth/space region
// descriptor generator.
// ----------------------------------------------------------------------------
package dsrd_pkg;

  localparam int unsigned DSRD_MAX_BLOCK = 8;
  localparam int unsigned DSRD_ADDR_BITS = 32;

  localparam int unsigned BS_W       = 4;
  localparam int unsigned BSQ_W      = 8;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned BATCH_W    = 8;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned SLOT_W     = 14;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_CHANNELS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_NHWC    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_CRD      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_TO_DEPTH = 3'd6;

  // effective (clamped) configuration
  typedef struct packed {
    logic [BS_W-1:0]  bs;
    logic [DIM_W-1:0] dh;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] sc;
    logic             nhwc;
    logic             crd;
    logic             s2d;
  } cfg_t;

  typedef struct packed {
    logic [BATCH_W-1:0] batch;
    logic [PHASE_W-1:0] row;
    logic [PHASE_W-1:0] col;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  region_slot;
    logic [FIELD_W-1:0] read_offset;
    logic [FIELD_W-1:0] read_stride_outer;
    logic [FIELD_W-1:0] read_stride_middle;
    logic [FIELD_W-1:0] read_stride_inner;
    logic [FIELD_W-1:0] write_offset;
    logic [FIELD_W-1:0] write_stride_outer;
    logic [FIELD_W-1:0] write_stride_middle;
    logic [FIELD_W-1:0] write_stride_inner;
    logic [DIM_W-1:0]   loop_rows;
    logic [DIM_W-1:0]   loop_cols;
    logic [DIM_W-1:0]   loop_chans;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/dsrd_front.sv
// ----------------------------------------------------------------------------
// dsrd_front
// Input stage: takes items, drops those whose phase lies outside the block
// and hands the rest to the queue.
// ----------------------------------------------------------------------------
module dsrd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dsrd_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dsrd_pkg::item_t in_item_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output dsrd_pkg::item_t item_o
);
  import dsrd_pkg::*;

  logic  valid_d, valid_q;
  item_t item_q;
  logic  accept;
  logic  in_block;

  assign in_ready_o = !valid_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_block   = ({1'b0, in_item_i.row} < cfg_i.bs) && ({1'b0, in_item_i.col} < cfg_i.bs);

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = in_block;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/core/dsrd_queue.sv
// ----------------------------------------------------------------------------
// dsrd_queue
// Short item queue between the input stage and the descriptor pipeline.
// ----------------------------------------------------------------------------
module dsrd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  dsrd_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output dsrd_pkg::item_t pop_item_o
);
  import dsrd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  item_t            entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_d, wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/core/dsrd_back.sv
// ----------------------------------------------------------------------------
// dsrd_back
// Descriptor pipeline: four product stages and an output register that
// build offsets, strides and loop counts of a region per cycle unless stalled.
// ----------------------------------------------------------------------------
module dsrd_back #(
  parameter int unsigned ADDR_BITS = dsrd_pkg::DSRD_ADDR_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsrd_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  dsrd_pkg::item_t   item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dsrd_pkg::result_t result_o
);
  import dsrd_pkg::*;

  localparam int unsigned OW    = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int unsigned DWH_W = 2 * DIM_W;
  localparam int unsigned SW_W  = DIM_W + BS_W;
  localparam int unsigned DC_W  = DIM_W + BSQ_W;

  typedef logic [OW-1:0] addr_t;

  logic advance;
  logic v1_q, v2_q, v3_q, v4_q, out_vld_q;

  // stage 1
  logic [BATCH_W-1:0] s1_batch_q;
  logic [PHASE_W-1:0] s1_row_q, s1_col_q;
  logic [BSQ_W-1:0]   s1_bsq_d, s1_bsq_q;
  logic [DWH_W-1:0]   s1_dwh_d, s1_dwh_q;
  logic [SW_W-1:0]    s1_sw_d, s1_sw_q;
  logic [SW_W-1:0]    s1_scbs_d, s1_scbs_q;
  logic [BSQ_W-1:0]   s1_craw_d, s1_craw_q;

  // stage 2
  logic [BATCH_W-1:0] s2_batch_q;
  logic [PHASE_W-1:0] s2_row_q, s2_col_q;
  logic [BSQ_W-1:0]   s2_bsq_q;
  logic [DWH_W-1:0]   s2_dwh_q;
  logic [SW_W-1:0]    s2_sw_q, s2_scbs_q;
  logic [DC_W-1:0]    s2_dc_d, s2_dc_q;
  addr_t              s2_s1p_d, s2_s1p_q;
  logic [SLOT_W-1:0]  s2_slot_d, s2_slot_q;
  logic [DC_W-1:0]    s2_csc_d, s2_csc_q;
  addr_t              s2_s2w_d, s2_s2w_q;

  // stage 3
  logic [BATCH_W-1:0] s3_batch_q;
  logic [SLOT_W-1:0]  s3_slot_q;
  addr_t              s3_d1, s3_s2;
  addr_t              s3_d0_d, s3_d0_q;
  addr_t              s3_d2_d, s3_d2_q;
  logic [FIELD_W-1:0] s3_d3_d, s3_d3_q;
  addr_t              s3_dsi_d, s3_dsi_q;
  addr_t              s3_sso_d, s3_sso_q;
  addr_t              s3_ssm_d, s3_ssm_q;
  addr_t              s3_ssi_d, s3_ssi_q;
  addr_t              s3_cd1_d, s3_cd1_q;
  addr_t              s3_hs2_d, s3_hs2_q;
  addr_t              s3_ws3_d, s3_ws3_q;

  // stage 4
  logic [SLOT_W-1:0]  s4_slot_q;
  addr_t              s4_bd0_d, s4_bd0_q;
  addr_t              s4_sp_d, s4_sp_q;
  addr_t              s4_cd1_q, s4_d2_q, s4_dsi_q;
  logic [FIELD_W-1:0] s4_d3_q;
  addr_t              s4_sso_q, s4_ssm_q, s4_ssi_q;

  // output register
  addr_t              doff, soff;
  result_t            res_d, res_q;

  assign advance      = !out_vld_q || out_ready_i;
  assign item_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      v1_q      <= item_valid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      out_vld_q <= v4_q;
    end
  end

  // stage 1: block square, depth area, space width, per-item channel phase
  always_comb begin
    s1_bsq_d  = BSQ_W'(cfg_i.bs) * BSQ_W'(cfg_i.bs);
    s1_dwh_d  = DWH_W'(cfg_i.dw) * DWH_W'(cfg_i.dh);
    s1_sw_d   = SW_W'(cfg_i.dw) * SW_W'(cfg_i.bs);
    s1_scbs_d = SW_W'(cfg_i.sc) * SW_W'(cfg_i.bs);
    s1_craw_d = BSQ_W'(item_i.row) * BSQ_W'(cfg_i.bs) + BSQ_W'(item_i.col);
  end

  // stage 2: depth channels, space plane, slot number
  always_comb begin
    s2_dc_d   = DC_W'(cfg_i.sc) * DC_W'(s1_bsq_q);
    s2_s1p_d  = addr_t'(s1_dwh_q) * addr_t'(s1_bsq_q);
    s2_slot_d = SLOT_W'(s1_batch_q) * SLOT_W'(s1_bsq_q) + SLOT_W'(s1_craw_q);
    s2_csc_d  = cfg_i.crd ? DC_W'(s1_craw_q) : DC_W'(s1_craw_q) * DC_W'(cfg_i.sc);
    s2_s2w_d  = addr_t'(s1_sw_q) * addr_t'(cfg_i.sc);
  end

  // stage 3: strides of both sides
  always_comb begin
    s3_d1    = cfg_i.nhwc ? addr_t'(1) : addr_t'(s2_dwh_q);
    s3_s2    = cfg_i.nhwc ? s2_s2w_q : addr_t'(s2_sw_q);
    s3_d0_d  = addr_t'(s2_dwh_q) * addr_t'(s2_dc_q);
    s3_d2_d  = cfg_i.nhwc ? addr_t'(cfg_i.dw) * addr_t'(s2_dc_q) : addr_t'(cfg_i.dw);
    s3_d3_d  = cfg_i.nhwc ? FIELD_W'(s2_dc_q) : FIELD_W'(1);
    s3_dsi_d = s3_d1;
    if (cfg_i.crd) begin
      s3_dsi_d = cfg_i.nhwc ? addr_t'(s2_bsq_q) : s2_s1p_q;
    end
    s3_ssi_d = cfg_i.nhwc ? addr_t'(1) : s2_s1p_q;
    s3_sso_d = s3_s2 * addr_t'(cfg_i.bs);
    s3_ssm_d = cfg_i.nhwc ? addr_t'(s2_scbs_q) : addr_t'(cfg_i.bs);
    s3_cd1_d = cfg_i.nhwc ? addr_t'(s2_csc_q) : addr_t'(s2_csc_q) * addr_t'(s2_dwh_q);
    s3_hs2_d = addr_t'(s2_row_q) * s3_s2;
    s3_ws3_d = cfg_i.nhwc ? addr_t'(s2_col_q) * addr_t'(cfg_i.sc) : addr_t'(s2_col_q);
  end

  // stage 4: batch base
  always_comb begin
    s4_bd0_d = addr_t'(s3_batch_q) * s3_d0_q;
    s4_sp_d  = s3_hs2_q + s3_ws3_q;
  end

  // output: offsets and side order
  always_comb begin
    doff = s4_bd0_q + s4_cd1_q;
    soff = s4_bd0_q + s4_sp_q;
    res_d.region_slot = s4_slot_q;
    if (cfg_i.s2d) begin
      res_d.read_offset         = FIELD_W'(soff);
      res_d.read_stride_outer   = FIELD_W'(s4_sso_q);
      res_d.read_stride_middle  = FIELD_W'(s4_ssm_q);
      res_d.read_stride_inner   = FIELD_W'(s4_ssi_q);
      res_d.write_offset        = FIELD_W'(doff);
      res_d.write_stride_outer  = FIELD_W'(s4_d2_q);
      res_d.write_stride_middle = s4_d3_q;
      res_d.write_stride_inner  = FIELD_W'(s4_dsi_q);
    end else begin
      res_d.read_offset         = FIELD_W'(doff);
      res_d.read_stride_outer   = FIELD_W'(s4_d2_q);
      res_d.read_stride_middle  = s4_d3_q;
      res_d.read_stride_inner   = FIELD_W'(s4_dsi_q);
      res_d.write_offset        = FIELD_W'(soff);
      res_d.write_stride_outer  = FIELD_W'(s4_sso_q);
      res_d.write_stride_middle = FIELD_W'(s4_ssm_q);
      res_d.write_stride_inner  = FIELD_W'(s4_ssi_q);
    end
    res_d.loop_rows  = cfg_i.dh;
    res_d.loop_cols  = cfg_i.dw;
    res_d.loop_chans = cfg_i.sc;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_batch_q <= item_i.batch;
      s1_row_q   <= item_i.row;
      s1_col_q   <= item_i.col;
      s1_bsq_q   <= s1_bsq_d;
      s1_dwh_q   <= s1_dwh_d;
      s1_sw_q    <= s1_sw_d;
      s1_scbs_q  <= s1_scbs_d;
      s1_craw_q  <= s1_craw_d;

      s2_batch_q <= s1_batch_q;
      s2_row_q   <= s1_row_q;
      s2_col_q   <= s1_col_q;
      s2_bsq_q   <= s1_bsq_q;
      s2_dwh_q   <= s1_dwh_q;
      s2_sw_q    <= s1_sw_q;
      s2_scbs_q  <= s1_scbs_q;
      s2_dc_q    <= s2_dc_d;
      s2_s1p_q   <= s2_s1p_d;
      s2_slot_q  <= s2_slot_d;
      s2_csc_q   <= s2_csc_d;
      s2_s2w_q   <= s2_s2w_d;

      s3_batch_q <= s2_batch_q;
      s3_slot_q  <= s2_slot_q;
      s3_d0_q    <= s3_d0_d;
      s3_d2_q    <= s3_d2_d;
      s3_d3_q    <= s3_d3_d;
      s3_dsi_q   <= s3_dsi_d;
      s3_sso_q   <= s3_sso_d;
      s3_ssm_q   <= s3_ssm_d;
      s3_ssi_q   <= s3_ssi_d;
      s3_cd1_q   <= s3_cd1_d;
      s3_hs2_q   <= s3_hs2_d;
      s3_ws3_q   <= s3_ws3_d;

      s4_slot_q  <= s3_slot_q;
      s4_bd0_q   <= s4_bd0_d;
      s4_sp_q    <= s4_sp_d;
      s4_cd1_q   <= s3_cd1_q;
      s4_d2_q    <= s3_d2_q;
      s4_d3_q    <= s3_d3_q;
      s4_dsi_q   <= s3_dsi_q;
      s4_sso_q   <= s3_sso_q;
      s4_ssm_q   <= s3_ssm_q;
      s4_ssi_q   <= s3_ssi_q;

      res_q      <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;

endmodule

>>> rtl/core/depth_space_region_descriptor_core.sv
// ----------------------------------------------------------------------------
// depth_space_region_descriptor_core
// Copy-region descriptor generator for depth-to-space and space-to-depth.
//
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// no item is in flight; a write takes effect at the next clock edge.
// Input items (batch, row phase, column phase) use a valid/ready channel.
// Items whose row or column phase is not below the block size are dropped
// and produce no descriptor.
// Each other item yields one descriptor on the valid/ready output channel,
// after passing an input register, a two-entry queue, four product stages
// (one multiplier deep each) and an output register.
// The pipeline sustains one descriptor per cycle while out_ready_i is high.
// When the receiver stalls, the product pipeline and output register hold;
// the queue and input register still take up to three more items before
// in_ready_o drops.
// Reset empties the pipeline and loads the register defaults: block size 2,
// all dimensions 1, NCHW, DCR, depth-to-space.
// ----------------------------------------------------------------------------
module depth_space_region_descriptor_core #(
  parameter int unsigned MAX_BLOCK = dsrd_pkg::DSRD_MAX_BLOCK,
  parameter int unsigned ADDR_BITS = dsrd_pkg::DSRD_ADDR_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dsrd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dsrd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dsrd_pkg::BATCH_W-1:0]        batch_index_i,
  input  logic [dsrd_pkg::PHASE_W-1:0]        row_phase_i,
  input  logic [dsrd_pkg::PHASE_W-1:0]        col_phase_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dsrd_pkg::SLOT_W-1:0]         region_slot_o,
  output logic [dsrd_pkg::FIELD_W-1:0]        read_offset_o,
  output logic [dsrd_pkg::FIELD_W-1:0]        read_stride_outer_o,
  output logic [dsrd_pkg::FIELD_W-1:0]        read_stride_middle_o,
  output logic [dsrd_pkg::FIELD_W-1:0]        read_stride_inner_o,
  output logic [dsrd_pkg::FIELD_W-1:0]        write_offset_o,
  output logic [dsrd_pkg::FIELD_W-1:0]        write_stride_outer_o,
  output logic [dsrd_pkg::FIELD_W-1:0]        write_stride_middle_o,
  output logic [dsrd_pkg::FIELD_W-1:0]        write_stride_inner_o,
  output logic [dsrd_pkg::DIM_W-1:0]          loop_rows_o,
  output logic [dsrd_pkg::DIM_W-1:0]          loop_cols_o,
  output logic [dsrd_pkg::DIM_W-1:0]          loop_chans_o
);
  import dsrd_pkg::*;

  localparam logic [BS_W:0] MAX_BS = (BS_W + 1)'(MAX_BLOCK);

  logic [BS_W-1:0]  block_size_d, block_size_q;
  logic [DIM_W-1:0] depth_height_d, depth_height_q;
  logic [DIM_W-1:0] depth_width_d, depth_width_q;
  logic [DIM_W-1:0] space_channels_d, space_channels_q;
  logic             layout_nhwc_d, layout_nhwc_q;
  logic             order_crd_d, order_crd_q;
  logic             space_to_depth_d, space_to_depth_q;

  cfg_t    cfg;
  item_t   in_item;
  item_t   fr_item, q_item;
  logic    fr_valid, q_ready;
  logic    q_valid, bk_ready;
  result_t result;

  // register writes
  always_comb begin
    block_size_d     = block_size_q;
    depth_height_d   = depth_height_q;
    depth_width_d    = depth_width_q;
    space_channels_d = space_channels_q;
    layout_nhwc_d    = layout_nhwc_q;
    order_crd_d      = order_crd_q;
    space_to_depth_d = space_to_depth_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLOCK_SIZE:     block_size_d     = cfg_wdata_i[BS_W-1:0];
        REG_DEPTH_HEIGHT:   depth_height_d   = cfg_wdata_i[DIM_W-1:0];
        REG_DEPTH_WIDTH:    depth_width_d    = cfg_wdata_i[DIM_W-1:0];
        REG_SPACE_CHANNELS: space_channels_d = cfg_wdata_i[DIM_W-1:0];
        REG_LAYOUT_NHWC:    layout_nhwc_d    = cfg_wdata_i[0];
        REG_ORDER_CRD:      order_crd_d      = cfg_wdata_i[0];
        REG_SPACE_TO_DEPTH: space_to_depth_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q     <= BS_W'(2);
      depth_height_q   <= DIM_W'(1);
      depth_width_q    <= DIM_W'(1);
      space_channels_q <= DIM_W'(1);
      layout_nhwc_q    <= 1'b0;
      order_crd_q      <= 1'b0;
      space_to_depth_q <= 1'b0;
    end else begin
      block_size_q     <= block_size_d;
      depth_height_q   <= depth_height_d;
      depth_width_q    <= depth_width_d;
      space_channels_q <= space_channels_d;
      layout_nhwc_q    <= layout_nhwc_d;
      order_crd_q      <= order_crd_d;
      space_to_depth_q <= space_to_depth_d;
    end
  end

  // effective configuration
  always_comb begin
    cfg.bs = block_size_q;
    if (block_size_q == '0) begin
      cfg.bs = BS_W'(1);
    end else if ({1'b0, block_size_q} > MAX_BS) begin
      cfg.bs = MAX_BS[BS_W-1:0];
    end
    cfg.dh   = clamp_dim(depth_height_q);
    cfg.dw   = clamp_dim(depth_width_q);
    cfg.sc   = clamp_dim(space_channels_q);
    cfg.nhwc = layout_nhwc_q;
    cfg.crd  = order_crd_q;
    cfg.s2d  = space_to_depth_q;
  end

  assign in_item.batch = batch_index_i;
  assign in_item.row   = row_phase_i;
  assign in_item.col   = col_phase_i;

  dsrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .item_valid_o (fr_valid),
    .item_ready_i (q_ready),
    .item_o       (fr_item)
  );

  dsrd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (q_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (q_item)
  );

  dsrd_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (q_valid),
    .item_ready_o (bk_ready),
    .item_i       (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign region_slot_o         = result.region_slot;
  assign read_offset_o         = result.read_offset;
  assign read_stride_outer_o   = result.read_stride_outer;
  assign read_stride_middle_o  = result.read_stride_middle;
  assign read_stride_inner_o   = result.read_stride_inner;
  assign write_offset_o        = result.write_offset;
  assign write_stride_outer_o  = result.write_stride_outer;
  assign write_stride_middle_o = result.write_stride_middle;
  assign write_stride_inner_o  = result.write_stride_inner;
  assign loop_rows_o           = result.loop_rows;
  assign loop_cols_o           = result.loop_cols;
  assign loop_chans_o          = result.loop_chans;

  // an out-of-block transfer never reaches the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o &&
     (({1'b0, row_phase_i} >= cfg.bs) || ({1'b0, col_phase_i} >= cfg.bs))) |=> !fr_valid)
    else $error("out-of-block item entered the queue path");

  // a full queue back-pressures the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && !q_ready) |-> !in_ready_o)
    else $error("input accepted while front stage is blocked");

  // loop counts are always clamped to a nonzero range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((loop_rows_o != '0) && (loop_cols_o != '0) && (loop_chans_o != '0) &&
                     (loop_rows_o <= DIM_MAX) && (loop_cols_o <= DIM_MAX) &&
                     (loop_chans_o <= DIM_MAX)))
    else $error("loop count out of range");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the depth/space region descriptor generator.
// A short table of directed requests walks reset defaults, clamped and
// oversized register values, every layout, channel order and direction, and
// phases outside the block. Then randomized register setups are each followed
// by a run of random requests. Every descriptor is compared field by field
// with a bit-accurate predictor. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import dsrd_pkg::*;

  localparam int PHASES        = 13;
  localparam int PHASE_ITEMS   = 125;
  localparam int CALM_PHASE    = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam longint unsigned ADDR_MASK = (64'd1 << DSRD_ADDR_BITS) - 64'd1;

  typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_TYPED, ROW_DROP} row_kind_e;

  typedef struct packed {
    logic [BS_W-1:0]  bs;
    logic [DIM_W-1:0] dh;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] sc;
    logic             nhwc;
    logic             crd;
    logic             s2d;
  } shadow_regs_t;

  typedef struct packed {
    row_kind_e           kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [BATCH_W-1:0]  batch;
    logic [PHASE_W-1:0]  row;
    logic [PHASE_W-1:0]  col;
    result_t             typed;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [BATCH_W-1:0]    batch_index_i = '0;
  logic [PHASE_W-1:0]    row_phase_i = '0;
  logic [PHASE_W-1:0]    col_phase_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [SLOT_W-1:0]     region_slot_o;
  logic [FIELD_W-1:0]    read_offset_o;
  logic [FIELD_W-1:0]    read_stride_outer_o;
  logic [FIELD_W-1:0]    read_stride_middle_o;
  logic [FIELD_W-1:0]    read_stride_inner_o;
  logic [FIELD_W-1:0]    write_offset_o;
  logic [FIELD_W-1:0]    write_stride_outer_o;
  logic [FIELD_W-1:0]    write_stride_middle_o;
  logic [FIELD_W-1:0]    write_stride_inner_o;
  logic [DIM_W-1:0]      loop_rows_o;
  logic [DIM_W-1:0]      loop_cols_o;
  logic [DIM_W-1:0]      loop_chans_o;

  logic         calm = 1'b0;
  shadow_regs_t shadow = '{bs: 4'd2, dh: 13'd1, dw: 13'd1, sc: 13'd1,
                           nhwc: 1'b0, crd: 1'b0, s2d: 1'b0};
  result_t      pending_descriptors[$];
  plan_row_t    plan[$];
  result_t      got;
  result_t      want;
  int           mismatches = 0;
  int           idle_cycles = 0;

  depth_space_region_descriptor_core uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .batch_index_i        (batch_index_i),
    .row_phase_i          (row_phase_i),
    .col_phase_i          (col_phase_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .region_slot_o        (region_slot_o),
    .read_offset_o        (read_offset_o),
    .read_stride_outer_o  (read_stride_outer_o),
    .read_stride_middle_o (read_stride_middle_o),
    .read_stride_inner_o  (read_stride_inner_o),
    .write_offset_o       (write_offset_o),
    .write_stride_outer_o (write_stride_outer_o),
    .write_stride_middle_o(write_stride_middle_o),
    .write_stride_inner_o (write_stride_inner_o),
    .loop_rows_o          (loop_rows_o),
    .loop_cols_o          (loop_cols_o),
    .loop_chans_o         (loop_chans_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned effective_block(input logic [BS_W-1:0] raw);
    longint unsigned v;
    v = 64'(raw);
    if (v == 0) v = 1;
    if (v > 64'(DSRD_MAX_BLOCK)) v = 64'(DSRD_MAX_BLOCK);
    return v;
  endfunction

  function automatic longint unsigned dim_in_range(input logic [DIM_W-1:0] raw);
    longint unsigned v;
    v = 64'(raw);
    if (v == 0) v = 1;
    if (v > 64'(DIM_MAX)) v = 64'(DIM_MAX);
    return v;
  endfunction

  // returns 0 when the phase lies outside the block and nothing is emitted
  function automatic bit compute_descriptor(input shadow_regs_t r,
                                            input logic [BATCH_W-1:0] b_in,
                                            input logic [PHASE_W-1:0] hb_in,
                                            input logic [PHASE_W-1:0] wb_in,
                                            output result_t d);
    longint unsigned bs, b, hb, wb, dh, dw, sc, dc, sh, sw;
    longint unsigned d0, d1, d2, d3, s0, s1, s2, s3, cidx;
    longint unsigned doff, dso, dsm, dsi, soff, sso, ssm, ssi;
    d = '0;
    bs = effective_block(r.bs);
    b  = 64'(b_in);
    hb = 64'(hb_in);
    wb = 64'(wb_in);
    if (hb >= bs || wb >= bs) return 1'b0;
    dh = dim_in_range(r.dh);
    dw = dim_in_range(r.dw);
    sc = dim_in_range(r.sc);
    dc = sc * bs * bs;
    sh = dh * bs;
    sw = dw * bs;
    d0 = (dw * dh * dc) & ADDR_MASK;
    s0 = (sw * sh * sc) & ADDR_MASK;
    if (r.nhwc) begin
      d1 = 1; d2 = (dw * dc) & ADDR_MASK; d3 = dc;
      s1 = 1; s2 = (sw * sc) & ADDR_MASK; s3 = sc;
    end else begin
      d1 = (dw * dh) & ADDR_MASK; d2 = dw; d3 = 1;
      s1 = (sh * sw) & ADDR_MASK; s2 = sw; s3 = 1;
    end
    // space side
    soff = (((b * s0) & ADDR_MASK) + hb * s2 + wb * s3) & ADDR_MASK;
    sso  = (s2 * bs) & ADDR_MASK;
    ssm  = (s3 * bs) & ADDR_MASK;
    ssi  = s1;
    // depth side
    cidx = hb * bs + wb;
    if (!r.crd) cidx = cidx * sc;
    doff = (((b * d0) & ADDR_MASK) + ((cidx * d1) & ADDR_MASK)) & ADDR_MASK;
    dso  = d2;
    dsm  = d3;
    dsi  = r.crd ? ((d1 * bs * bs) & ADDR_MASK) : d1;

    d.region_slot         = SLOT_W'(b * bs * bs + hb * bs + wb);
    d.read_offset         = FIELD_W'(r.s2d ? soff : doff);
    d.read_stride_outer   = FIELD_W'(r.s2d ? sso : dso);
    d.read_stride_middle  = FIELD_W'(r.s2d ? ssm : dsm);
    d.read_stride_inner   = FIELD_W'(r.s2d ? ssi : dsi);
    d.write_offset        = FIELD_W'(r.s2d ? doff : soff);
    d.write_stride_outer  = FIELD_W'(r.s2d ? dso : sso);
    d.write_stride_middle = FIELD_W'(r.s2d ? dsm : ssm);
    d.write_stride_inner  = FIELD_W'(r.s2d ? dsi : ssi);
    d.loop_rows           = DIM_W'(dh);
    d.loop_cols           = DIM_W'(dw);
    d.loop_chans          = DIM_W'(sc);
    return 1'b1;
  endfunction

  function automatic result_t descriptor(input logic [SLOT_W-1:0] slot,
                                         input logic [FIELD_W-1:0] ro, rso, rsm, rsi,
                                         input logic [FIELD_W-1:0] wo, wso, wsm, wsi,
                                         input logic [DIM_W-1:0] rows, cols, chans);
    result_t d;
    d.region_slot         = slot;
    d.read_offset         = ro;
    d.read_stride_outer   = rso;
    d.read_stride_middle  = rsm;
    d.read_stride_inner   = rsi;
    d.write_offset        = wo;
    d.write_stride_outer  = wso;
    d.write_stride_middle = wsm;
    d.write_stride_inner  = wsi;
    d.loop_rows           = rows;
    d.loop_cols           = cols;
    d.loop_chans          = chans;
    return d;
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    plan_row_t p;
    p = '0;
    p.kind = ROW_WRITE;
    p.idx  = idx;
    p.val  = val;
    return p;
  endfunction

  function automatic plan_row_t item_row(input row_kind_e kind,
                                         input logic [BATCH_W-1:0] b,
                                         input logic [PHASE_W-1:0] r,
                                         input logic [PHASE_W-1:0] c,
                                         input result_t typed);
    plan_row_t p;
    p = '0;
    p.kind  = kind;
    p.batch = b;
    p.row   = r;
    p.col   = c;
    p.typed = typed;
    return p;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    logic [DIM_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = DIM_MAX;
      2:       v = DIM_W'($urandom_range(4097, 8191));
      3, 4:    v = DIM_W'($urandom_range(0, 8191));
      default: v = DIM_W'($urandom_range(1, 16));
    endcase
    return v;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_BLOCK_SIZE:     shadow.bs   = val[BS_W-1:0];
      REG_DEPTH_HEIGHT:   shadow.dh   = val;
      REG_DEPTH_WIDTH:    shadow.dw   = val;
      REG_SPACE_CHANNELS: shadow.sc   = val;
      REG_LAYOUT_NHWC:    shadow.nhwc = val[0];
      REG_ORDER_CRD:      shadow.crd  = val[0];
      REG_SPACE_TO_DEPTH: shadow.s2d  = val[0];
      default: ;
    endcase
  endtask

  // drop valid, drain all descriptors, then let dropped requests flush out
  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    while (pending_descriptors.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic issue(input row_kind_e kind, input logic [BATCH_W-1:0] b,
                       input logic [PHASE_W-1:0] r, input logic [PHASE_W-1:0] c,
                       input result_t typed);
    result_t d;
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    batch_index_i <= b;
    row_phase_i   <= r;
    col_phase_i   <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    case (kind)
      ROW_TYPED: pending_descriptors.push_back(typed);
      ROW_ITEM:  if (compute_descriptor(shadow, b, r, c, d)) pending_descriptors.push_back(d);
      default: ;
    endcase
  endtask

  task automatic random_setup();
    settle_pipeline();
    program_reg(REG_BLOCK_SIZE, {9'($urandom_range(0, 511)),
                                 ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 8))
                                                            : 4'($urandom_range(0, 15))});
    program_reg(REG_DEPTH_HEIGHT, pick_dim());
    program_reg(REG_DEPTH_WIDTH, pick_dim());
    program_reg(REG_SPACE_CHANNELS, pick_dim());
    program_reg(REG_LAYOUT_NHWC, CFG_DATA_W'($urandom_range(0, 8191)));
    program_reg(REG_ORDER_CRD, CFG_DATA_W'($urandom_range(0, 8191)));
    program_reg(REG_SPACE_TO_DEPTH, CFG_DATA_W'($urandom_range(0, 8191)));
    if ($urandom_range(0, 3) == 0) program_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 8191)));
    cfg_we_i <= 1'b0;
  endtask

  // descriptor checker and receiver idling
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = descriptor(region_slot_o, read_offset_o, read_stride_outer_o,
                       read_stride_middle_o, read_stride_inner_o, write_offset_o,
                       write_stride_outer_o, write_stride_middle_o,
                       write_stride_inner_o, loop_rows_o, loop_cols_o, loop_chans_o);
      if (pending_descriptors.size() == 0) begin
        $error("descriptor transfer with nothing pending, slot 0x%0h", got.region_slot);
        mismatches++;
      end else begin
        want = pending_descriptors.pop_front();
        check_field("region_slot", 32'(want.region_slot), 32'(got.region_slot));
        check_field("read_offset", want.read_offset, got.read_offset);
        check_field("read_stride_outer", want.read_stride_outer, got.read_stride_outer);
        check_field("read_stride_middle", want.read_stride_middle, got.read_stride_middle);
        check_field("read_stride_inner", want.read_stride_inner, got.read_stride_inner);
        check_field("write_offset", want.write_offset, got.write_offset);
        check_field("write_stride_outer", want.write_stride_outer, got.write_stride_outer);
        check_field("write_stride_middle", want.write_stride_middle,
                    got.write_stride_middle);
        check_field("write_stride_inner", want.write_stride_inner, got.write_stride_inner);
        check_field("loop_rows", 32'(want.loop_rows), 32'(got.loop_rows));
        check_field("loop_cols", 32'(want.loop_cols), 32'(got.loop_cols));
        check_field("loop_chans", 32'(want.loop_chans), 32'(got.loop_chans));
      end
    end
    out_ready_i <= calm || ($urandom_range(0, 99) >= 30);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit writing;
    int p;
    int n;
    longint unsigned bs_now;
    logic [BATCH_W-1:0] b;
    logic [PHASE_W-1:0] r;
    logic [PHASE_W-1:0] c;

    // reset defaults: block 2, all dims 1, nchw, dcr, depth-to-space
    plan.push_back(item_row(ROW_TYPED, 8'd0, 3'd0, 3'd0,
                            descriptor(0, 0, 1, 1, 1, 0, 4, 2, 4, 1, 1, 1)));
    plan.push_back(item_row(ROW_TYPED, 8'd255, 3'd1, 3'd1,
                            descriptor(1023, 1023, 1, 1, 1, 1023, 4, 2, 4, 1, 1, 1)));
    plan.push_back(item_row(ROW_DROP, 8'd0, 3'd2, 3'd0, '0));
    plan.push_back(item_row(ROW_DROP, 8'd3, 3'd0, 3'd7, '0));
    // zero block size and zero dims act as 1
    plan.push_back(write_row(REG_BLOCK_SIZE, 13'd0));
    plan.push_back(write_row(REG_DEPTH_HEIGHT, 13'd0));
    plan.push_back(write_row(REG_DEPTH_WIDTH, 13'd0));
    plan.push_back(write_row(REG_SPACE_CHANNELS, 13'd0));
    plan.push_back(item_row(ROW_TYPED, 8'd255, 3'd0, 3'd0,
                            descriptor(255, 255, 1, 1, 1, 255, 1, 1, 1, 1, 1, 1)));
    plan.push_back(item_row(ROW_DROP, 8'd0, 3'd1, 3'd0, '0));
    plan.push_back(item_row(ROW_DROP, 8'd0, 3'd0, 3'd1, '0));
    // oversized values clamp, nhwc crd space-to-depth
    plan.push_back(write_row(REG_BLOCK_SIZE, 13'd15));
    plan.push_back(write_row(REG_DEPTH_HEIGHT, 13'd8191));
    plan.push_back(write_row(REG_DEPTH_WIDTH, 13'd4096));
    plan.push_back(write_row(REG_SPACE_CHANNELS, 13'd8191));
    plan.push_back(write_row(REG_LAYOUT_NHWC, 13'd1));
    plan.push_back(write_row(REG_ORDER_CRD, 13'd1));
    plan.push_back(write_row(REG_SPACE_TO_DEPTH, 13'd1));
    plan.push_back(write_row(REG_SPARE, 13'd8191));
    plan.push_back(item_row(ROW_ITEM, 8'd255, 3'd7, 3'd7, '0));
    plan.push_back(item_row(ROW_ITEM, 8'd0, 3'd7, 3'd0, '0));
    plan.push_back(item_row(ROW_ITEM, 8'd128, 3'd0, 3'd7, '0));
    plan.push_back(item_row(ROW_ITEM, 8'd0, 3'd0, 3'd0, '0));
    // largest block, nchw crd depth-to-space
    plan.push_back(write_row(REG_BLOCK_SIZE, 13'd8));
    plan.push_back(write_row(REG_DEPTH_HEIGHT, 13'd4096));
    plan.push_back(write_row(REG_DEPTH_WIDTH, 13'd8191));
    plan.push_back(write_row(REG_SPACE_CHANNELS, 13'd4096));
    plan.push_back(write_row(REG_LAYOUT_NHWC, 13'd0));
    plan.push_back(write_row(REG_SPACE_TO_DEPTH, 13'd0));
    plan.push_back(item_row(ROW_ITEM, 8'd255, 3'd7, 3'd7, '0));
    plan.push_back(item_row(ROW_ITEM, 8'd1, 3'd3, 3'd5, '0));
    plan.push_back(item_row(ROW_ITEM, 8'd64, 3'd6, 3'd1, '0));
    // block one above max, nhwc dcr space-to-depth
    plan.push_back(write_row(REG_BLOCK_SIZE, 13'd9));
    plan.push_back(write_row(REG_LAYOUT_NHWC, 13'd1));
    plan.push_back(write_row(REG_ORDER_CRD, 13'd0));
    plan.push_back(write_row(REG_SPACE_TO_DEPTH, 13'd1));
    plan.push_back(item_row(ROW_ITEM, 8'd255, 3'd7, 3'd7, '0));
    plan.push_back(item_row(ROW_ITEM, 8'd85, 3'd5, 3'd2, '0));
    // odd block, small dims, upper data bits ignored
    plan.push_back(write_row(REG_BLOCK_SIZE, 13'h1ff3));
    plan.push_back(write_row(REG_DEPTH_HEIGHT, 13'd1));
    plan.push_back(write_row(REG_DEPTH_WIDTH, 13'd7));
    plan.push_back(write_row(REG_SPACE_CHANNELS, 13'd5));
    plan.push_back(write_row(REG_LAYOUT_NHWC, 13'h1ffe));
    plan.push_back(item_row(ROW_ITEM, 8'd10, 3'd2, 3'd2, '0));
    plan.push_back(item_row(ROW_DROP, 8'd10, 3'd3, 3'd0, '0));
    plan.push_back(item_row(ROW_ITEM, 8'd170, 3'd0, 3'd2, '0));
    plan.push_back(item_row(ROW_DROP, 8'd0, 3'd2, 3'd3, '0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!writing) settle_pipeline();
        program_reg(plan[i].idx, plan[i].val);
        writing = 1'b1;
      end else begin
        if (writing) cfg_we_i <= 1'b0;
        writing = 1'b0;
        issue(plan[i].kind, plan[i].batch, plan[i].row, plan[i].col, plan[i].typed);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      random_setup();
      calm <= (p == CALM_PHASE);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        bs_now = effective_block(shadow.bs);
        b = BATCH_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85) begin
          r = PHASE_W'($urandom_range(0, int'(bs_now) - 1));
          c = PHASE_W'($urandom_range(0, int'(bs_now) - 1));
        end else begin
          r = PHASE_W'($urandom_range(0, 7));
          c = PHASE_W'($urandom_range(0, 7));
        end
        issue(ROW_ITEM, b, r, c, '0);
      end
    end

    settle_pipeline();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
